>>> rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the Mandelbrot escape counter.
// ----------------------------------------------------------------------------
package mec_pkg;

    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int COUNT_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;

    // Word index of the configuration registers (paddr[2])
    localparam logic REG_MAX_ITER = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic load;   // capture point, clear z and count
        logic mul;    // register the three products
        logic step;   // write back new z, bump count
        logic emit;   // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic finish;
    } t_dp_status;

endpackage

>>> rtl/mec_dp.sv
// ----------------------------------------------------------------------------
// mec_dp
// Datapath: product registers, z update with saturation, escape test,
// iteration counter and output register.
// ----------------------------------------------------------------------------
module mec_dp import mec_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    output t_dp_status                o_status,
    input  logic signed [DATA_W-1:0]  i_c_real,
    input  logic signed [DATA_W-1:0]  i_c_imag,
    input  logic        [COUNT_W-1:0] i_max_iter,
    output logic        [COUNT_W-1:0] o_escape_count
);

    localparam logic [PROD_W-1:0] MAG_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

    localparam logic signed [PROD_W-1:0] SAT_MAX = (PROD_W'(1) <<< (DATA_W - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(1) <<< (DATA_W - 1));

    function automatic logic signed [DATA_W-1:0] sat_data(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[DATA_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[DATA_W-1:0];
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    logic signed [DATA_W-1:0]  r_c_real;
    logic signed [DATA_W-1:0]  r_c_imag;
    logic signed [DATA_W-1:0]  r_zr;
    logic signed [DATA_W-1:0]  r_zi;
    logic        [COUNT_W-1:0] r_count;
    logic signed [PROD_W-1:0]  r_rr;
    logic signed [PROD_W-1:0]  r_ii;
    logic signed [PROD_W-1:0]  r_ri;
    logic        [COUNT_W-1:0] r_escape_count;

    logic signed [PROD_W-1:0]  re_sum;
    logic signed [PROD_W-1:0]  im_sum;
    logic signed [DATA_W-1:0]  n_zr;
    logic signed [DATA_W-1:0]  n_zi;
    logic        [PROD_W-1:0]  mag;

    // floor shift is the arithmetic shift right
    assign re_sum = ((r_rr - r_ii) >>> FRAC_BITS) + PROD_W'(r_c_real);
    assign im_sum = (r_ri >>> (FRAC_BITS - 1)) + PROD_W'(r_c_imag);
    assign n_zr   = sat_data(re_sum);
    assign n_zi   = sat_data(im_sum);

    // the squares of the current z are already in the product registers
    assign mag = $unsigned(r_rr) + $unsigned(r_ii);

    // count of zero means the first iteration has not run yet
    assign o_status.finish = (r_count != '0) &&
                             ((mag >= MAG_LIMIT) || (r_count >= i_max_iter));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c_real <= i_c_real;
            r_c_imag <= i_c_imag;
            r_zr     <= '0;
            r_zi     <= '0;
            r_count  <= '0;
        end else if (i_cmd.step) begin
            r_zr     <= n_zr;
            r_zi     <= n_zi;
            r_count  <= r_count + COUNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_rr <= r_zr * r_zr;
            r_ii <= r_zi * r_zi;
            r_ri <= r_zr * r_zi;
        end
        if (i_cmd.emit) begin
            r_escape_count <= r_count;
        end
    end

    assign o_escape_count = r_escape_count;

endmodule

>>> rtl/mec_ctrl.sv
// ----------------------------------------------------------------------------
// mec_ctrl
// Controller: sequences multiply and update cycles per iteration and owns
// the request handshakes on both channels.
// ----------------------------------------------------------------------------
module mec_ctrl import mec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // output slot is free if empty or being drained this cycle
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_UPD;
            end
            ST_UPD: begin
                if (i_status.finish) begin
                    // hold here until the output register can take the count
                    if (out_free) begin
                        o_cmd.emit = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

endmodule

>>> rtl/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Mandelbrot escape-time counter for one point c in signed fixed point.
// ----------------------------------------------------------------------------
// Each accepted point c runs z = z*z + c from z = 0 until |z|^2 reaches 4.0
// or the count reaches max_iterations, and returns the count (at least 1).
// Each iteration runs a multiply state in the three 32x32 multipliers
// (zr*zr, zi*zi, zr*zi registered), then an update state for the z update
// with saturation and the escape compare, which reuses the registered squares.
// A point is not taken while the block is busy: the next point is accepted
// only after the previous count has been loaded into the output register.
// The finished count sits in an output register, so a new point is taken
// while the previous count waits.
// max_iterations is at APB byte address 0 (reset 256); write it only while
// the block is idle.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count import mec_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_W-1:0]     i_c_real,
    input  logic signed [DATA_W-1:0]     i_c_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic        [COUNT_W-1:0]    o_escape_count,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic        [APB_ADDR_W-1:0] paddr,
    input  logic        [APB_DATA_W-1:0] pwdata,
    output logic        [APB_DATA_W-1:0] prdata,
    output logic                         pready
);

    logic [COUNT_W-1:0] r_max_iter;
    logic               reg_wr;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ITER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= MAX_ITER_RESET;
        end else if (reg_wr) begin
            r_max_iter <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_MAX_ITER: prdata = APB_DATA_W'(r_max_iter);
            default:      prdata = '0;
        endcase
    end

    mec_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    mec_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_c_real       (i_c_real),
        .i_c_imag       (i_c_imag),
        .i_max_iter     (r_max_iter),
        .o_escape_count (o_escape_count)
    );

endmodule

>>> dv/tb_mandelbrot_escape_count.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_count
// Self-checking bench for the Mandelbrot escape counter: a fixed-point
// predictor computes the count of every accepted point, and each returned
// count is compared in order against it. Directed corner points and limits
// come first, then random points near the set boundary plus full-range noise
// across several iteration limits, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
import mec_pkg::*;

class escape_count_board #(int FRAC = 28);

    typedef struct {
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
        logic        [COUNT_W-1:0] count;
    } t_pending;

    t_pending           pending[$];
    logic [COUNT_W-1:0] iter_limit = MAX_ITER_RESET;
    int                 errors = 0;
    int                 checked = 0;

    function longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000)
            return -64'sh8000_0000;
        return v;
    endfunction

    // z = z*z + c in fixed point, floor on the rescale, saturate each component
    function logic [COUNT_W-1:0] escape_count_of(logic signed [DATA_W-1:0] cr,
                                                 logic signed [DATA_W-1:0] ci);
        longint          zr;
        longint          zi;
        longint          nr;
        longint          ni;
        longint unsigned mag;
        longint unsigned bound;
        int unsigned     n;
        zr    = 0;
        zi    = 0;
        n     = 0;
        bound = 64'd4 << (2 * FRAC);
        do begin
            nr  = ((zr * zr - zi * zi) >>> FRAC) + longint'(cr);
            ni  = ((zr * zi) >>> (FRAC - 1)) + longint'(ci);
            zr  = clamp32(nr);
            zi  = clamp32(ni);
            mag = zr * zr;
            mag += zi * zi;
            n++;
        end while (mag < bound && n < iter_limit);
        return n[COUNT_W-1:0];
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task note_point(logic signed [DATA_W-1:0] cr, logic signed [DATA_W-1:0] ci);
        t_pending p;
        p.c_real = cr;
        p.c_imag = ci;
        p.count  = escape_count_of(cr, ci);
        pending.push_back(p);
    endtask

    task check_count(logic [COUNT_W-1:0] got);
        t_pending p;
        checked++;
        if (pending.size() == 0) begin
            report($sformatf("count %0d returned with no point outstanding", got));
            return;
        end
        p = pending.pop_front();
        if (got !== p.count)
            report($sformatf("c=(%h,%h) limit %0d: count %0d, expected %0d",
                             p.c_real, p.c_imag, iter_limit, got, p.count));
    endtask

endclass

module tb_mandelbrot_escape_count;

    localparam int FRAC_BITS   = 28;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_ITER = {REG_MAX_ITER, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'b100;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic signed [DATA_W-1:0]     i_c_real;
    logic signed [DATA_W-1:0]     i_c_imag;
    logic                         o_valid;
    logic                         i_stall;
    logic        [COUNT_W-1:0]    o_escape_count;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic        [APB_ADDR_W-1:0] paddr;
    logic        [APB_DATA_W-1:0] pwdata;
    logic        [APB_DATA_W-1:0] prdata;
    logic                         pready;

    escape_count_board #(FRAC_BITS) sb;

    int cycle_count     = 0;
    int hold_off_cycles = 0;
    int points_sent     = 0;
    bit src_burst       = 1'b0;
    bit snk_burst       = 1'b0;

    mandelbrot_escape_count #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_c_real      (i_c_real),
        .i_c_imag      (i_c_imag),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_escape_count(o_escape_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d counts outstanding",
                     cycle_count, sb.pending.size());
            $display("** mandelbrot_escape_count: FAILED **");
            $finish;
        end
    end

    // Result side: random stall before each count, plus one long hold-off on request
    initial begin : count_sink
        int gap;
        int taken;
        taken = 0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            if (taken % 30 == 0)
                snk_burst = ($urandom_range(0, 3) == 0);
            gap = snk_burst ? 0 : $urandom_range(0, 18);
            if (hold_off_cycles > 0) begin
                gap = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_count(o_escape_count);
            taken++;
        end
    end

    // Valid stays high across back-to-back requests; it only drops for a gap.
    task automatic send_point(input logic signed [DATA_W-1:0] cr,
                              input logic signed [DATA_W-1:0] ci);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_c_real <= cr;
        i_c_imag <= ci;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(cr, ci);
        points_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_back_limit();
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, ADDR_MAX_ITER, '0, rd);
        if (rd[COUNT_W-1:0] !== sb.iter_limit)
            sb.report($sformatf("max_iterations reads %0d, expected %0d",
                                rd[COUNT_W-1:0], sb.iter_limit));
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_MAX_ITER, APB_DATA_W'(value), rd);
        sb.iter_limit = value;
        read_back_limit();
    endtask

    initial begin : stimulus
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic        [COUNT_W-1:0] lim;
        logic        [APB_DATA_W-1:0] rd;
        sb = new();
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_c_real <= '0;
        i_c_imag <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        read_back_limit();

        // reset limit: corners, escape on the first step, periodic interior points
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000);
        send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh0000_0000, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh0000_0000);
        send_point(32'shE000_0000, 32'sh0000_0000);
        send_point(32'shE000_0001, 32'sh0000_0000);
        send_point(32'sh1FFF_FFFF, 32'sh0000_0000);
        send_point(32'sh0400_0000, 32'sh0000_0000);
        send_point(32'sh0428_F5C3, 32'sh0000_0000);
        send_point(32'shF000_0000, 32'sh0000_0000);
        send_point(32'sh0000_0000, 32'sh1000_0000);
        send_point(32'shF400_0000, 32'sh0199_999A);
        send_point(32'shFFFF_FFFF, 32'sh0000_0001);

        // zero limit still runs one iteration
        settle();
        write_limit('0);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh1FFF_FFFF, 32'sh0000_0000);
        send_point(32'sh0800_0000, 32'shF800_0000);

        settle();
        write_limit(16'd1);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        // write to an unmapped index must leave the limit alone
        settle();
        apb_access(1'b1, ADDR_UNMAPPED, $urandom, rd);
        read_back_limit();
        send_point(32'shF000_0000, 32'sh0000_0000);

        settle();
        write_limit(16'hFFFF);
        send_point(32'sh0000_0000, 32'sh0000_0000);
        send_point(32'sh0428_F5C3, 32'sh0000_0000);
        send_point(32'sh1FFF_FFFF, 32'sh1FFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            if (ph == 0)
                lim = MAX_ITER_RESET;
            else if (ph % 2)
                lim = COUNT_W'($urandom_range(2, 40));
            else
                lim = COUNT_W'($urandom_range(41, 300));
            write_limit(lim);
            for (int k = 0; k < 75; k++) begin
                if (k % 25 == 0)
                    src_burst = ($urandom_range(0, 3) == 0);
                // short limits make the block fill up fast behind a stalled result
                if (ph == 1 && k == 10)
                    hold_off_cycles = 400;
                if (ph == 3 && k == 40)
                    settle();
                case ($urandom_range(0, 9)) inside
                    [0:1]: begin
                        cr = $urandom;
                        ci = $urandom;
                    end
                    default: begin
                        // re in [-2.0, 0.5], im in [-1.25, 1.25]
                        cr = 32'shE000_0000 + $urandom_range(0, 671088640);
                        ci = -32'sd335544320 + $urandom_range(0, 671088640);
                    end
                endcase
                send_point(cr, ci);
            end
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("Ran %0d points over limits 0, 1, 256, 65535 and five random settings;",
                 points_sent);
        $display("%0d counts checked, %0d mismatches, with stalls and a long output hold-off",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("** mandelbrot_escape_count: PASSED **");
        else
            $display("** mandelbrot_escape_count: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/mec_pkg.sv
rtl/mec_dp.sv
rtl/mec_ctrl.sv
rtl/mandelbrot_escape_count.sv
dv/tb_mandelbrot_escape_count.sv
